[design/sai_pkg.sv]
// ----------------------------------------------------------------------------
// sai_pkg: shared types and constants of the sorted table insert core
// Operation and status codes, payload widths and the command and status
// groups that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package sai_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int VALUE_W       = 32;
    localparam int RANK_W        = 4;
    localparam int POS_W         = 4;
    localparam int COUNT_W       = 5;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_READ_OK  = 2'd2,
        ST_NO_RANK  = 2'd3
    } t_status;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    latch_in;     // capture the request beat
        logic    load_search;  // lo = 0, hi = count
        logic    search_rd;    // read the entry at mid
        logic    search_upd;   // narrow lo/hi from the entry read
        logic    shift_prime;  // w = count, read entry count-1
        logic    shift_run;    // move one entry up, read the next one down
        logic    write_new;    // store the value at lo, bump the count
        logic    rank_rd;      // read the entry at the requested rank
        logic    load_out;     // fill the result register
        t_status code;         // status of the result being loaded
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_op  op;
        logic full;
        logic rank_ok;
        logic search_done;
        logic no_shift;
        logic shift_last;
        logic out_free;
    } t_stat;

endpackage

[design/sai_in_if.sv]
// ----------------------------------------------------------------------------
// sai_in_if: request channel
// Valid/ready channel that carries one operation per beat.
// ----------------------------------------------------------------------------
interface sai_in_if;
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic signed [sai_pkg::VALUE_W-1:0] value;
    logic [sai_pkg::RANK_W-1:0]        rank;

    modport source (output valid, output operation, output value, output rank,
                    input ready);
    modport sink   (input valid, input operation, input value, input rank,
                    output ready);
endinterface

[design/sai_out_if.sv]
// ----------------------------------------------------------------------------
// sai_out_if: result channel
// Valid/ready channel that carries one result per beat.
// ----------------------------------------------------------------------------
interface sai_out_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic [sai_pkg::POS_W-1:0]          position;
    logic signed [sai_pkg::VALUE_W-1:0] data;
    logic [sai_pkg::COUNT_W-1:0]        count;

    modport source (output valid, output status, output position, output data,
                    output count, input ready);
    modport sink   (input valid, input status, input position, input data,
                    input count, output ready);
endinterface

[design/sai_datapath.sv]
// ----------------------------------------------------------------------------
// sai_datapath: table memory, search bounds and result register
// Holds the sorted entries in a one-write, one-read memory with a registered
// read port, the binary search bounds, the shift pointer and the result beat.
// ----------------------------------------------------------------------------
module sai_datapath #(
    parameter int DEPTH = sai_pkg::DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sai_pkg::t_cmd  i_cmd,
    output sai_pkg::t_stat o_stat,
    sai_in_if.sink         i_req,
    sai_out_if.source      o_rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = CW + sai_pkg::COUNT_W;
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic signed [sai_pkg::VALUE_W-1:0] mem [DEPTH];

    logic signed [sai_pkg::VALUE_W-1:0] r_value;
    sai_pkg::t_op                       r_op;
    logic [sai_pkg::RANK_W-1:0]         r_rank;
    logic [CW-1:0]                      r_count;
    logic [CW-1:0]                      r_lo;
    logic [CW-1:0]                      r_hi;
    logic [CW-1:0]                      r_w;
    logic signed [sai_pkg::VALUE_W-1:0] r_rd_data;

    logic                               r_out_valid;
    logic [1:0]                         r_out_status;
    logic [sai_pkg::POS_W-1:0]          r_out_pos;
    logic signed [sai_pkg::VALUE_W-1:0] r_out_data;
    logic [sai_pkg::COUNT_W-1:0]        r_out_count;

    logic [CW-1:0]                      mid;
    logic [CW-1:0]                      cnt_m1;
    logic [CW-1:0]                      w_m1;
    logic [CW-1:0]                      w_m2;
    logic [EW-1:0]                      rank_ext;
    logic [EW-1:0]                      count_ext;
    logic [EW-1:0]                      lo_ext;
    logic                               we;
    logic [AW-1:0]                      waddr;
    logic signed [sai_pkg::VALUE_W-1:0] wdata;
    logic                               re;
    logic [AW-1:0]                      raddr;

    assign mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign cnt_m1    = r_count - CW'(1);
    assign w_m1      = r_w - CW'(1);
    assign w_m2      = r_w - CW'(2);
    assign rank_ext  = EW'(r_rank);
    assign count_ext = EW'(r_count);
    assign lo_ext    = EW'(r_lo);

    // The request beat is taken only by the controller's idle state.
    assign i_req.ready = i_cmd.latch_in;

    // Memory port selection. Only one command is active in a cycle.
    always_comb begin
        we    = 1'b0;
        waddr = r_w[AW-1:0];
        wdata = r_rd_data;
        re    = 1'b0;
        raddr = mid[AW-1:0];
        if (i_cmd.shift_run) begin
            we    = 1'b1;
            re    = 1'b1;
            raddr = w_m2[AW-1:0];
        end else if (i_cmd.write_new) begin
            we    = 1'b1;
            waddr = r_lo[AW-1:0];
            wdata = r_value;
        end else if (i_cmd.shift_prime) begin
            // The shift pointer is loaded in this same cycle, so the top
            // entry is addressed from the count directly.
            re    = 1'b1;
            raddr = cnt_m1[AW-1:0];
        end else if (i_cmd.rank_rd) begin
            re    = 1'b1;
            raddr = rank_ext[AW-1:0];
        end else if (i_cmd.search_rd) begin
            re    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            r_rd_data <= mem[raddr];
        end
    end

    // Request capture, search bounds and shift pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op    <= sai_pkg::t_op'(i_req.operation);
            r_value <= i_req.value;
            r_rank  <= i_req.rank;
        end
        if (i_cmd.load_search) begin
            r_lo <= '0;
            r_hi <= r_count;
        end else if (i_cmd.search_upd) begin
            // Upper bound: equal entries stay below the new value.
            if (r_rd_data <= r_value) begin
                r_lo <= mid + CW'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.shift_prime) begin
            r_w <= r_count;
        end else if (i_cmd.shift_run) begin
            r_w <= w_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.write_new) begin
            r_count <= r_count + CW'(1);
        end
    end

    // Result register; it frees the controller while the beat waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.code;
            r_out_count  <= count_ext[sai_pkg::COUNT_W-1:0];
            r_out_pos    <= (i_cmd.code == sai_pkg::ST_INSERTED)
                            ? lo_ext[sai_pkg::POS_W-1:0] : '0;
            r_out_data   <= (i_cmd.code == sai_pkg::ST_READ_OK) ? r_rd_data : '0;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.status   = r_out_status;
    assign o_rsp.position = r_out_pos;
    assign o_rsp.data     = r_out_data;
    assign o_rsp.count    = r_out_count;

    always_comb begin
        o_stat.op          = r_op;
        o_stat.full        = (r_count == FULL_CNT);
        o_stat.rank_ok     = (rank_ext < count_ext);
        o_stat.search_done = (r_lo >= r_hi);
        o_stat.no_shift    = (r_lo == r_count);
        o_stat.shift_last  = (w_m1 == r_lo);
        o_stat.out_free    = !r_out_valid || o_rsp.ready;
    end

endmodule

[design/sai_ctrl.sv]
// ----------------------------------------------------------------------------
// sai_ctrl: sequencing of search, shift and read
// One-hot state machine that steps the datapath through one request at a
// time and chooses the status of each result.
// ----------------------------------------------------------------------------
module sai_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  sai_pkg::t_stat i_stat,
    output sai_pkg::t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECIDE   = 8'b0000_0010,
        S_SRCH_RD  = 8'b0000_0100,
        S_SRCH_CMP = 8'b0000_1000,
        S_SH_RUN   = 8'b0001_0000,
        S_WRITE    = 8'b0010_0000,
        S_RESULT   = 8'b0100_0000,
        S_SPARE    = 8'b1000_0000
    } t_state;

    t_state           r_state;
    t_state           n_state;
    sai_pkg::t_status r_code;
    sai_pkg::t_status n_code;

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        o_cmd.code = r_code;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.latch_in = 1'b1;
                if (i_req_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.op == sai_pkg::OP_INSERT) begin
                    if (i_stat.full) begin
                        n_code  = sai_pkg::ST_FULL;
                        n_state = S_RESULT;
                    end else begin
                        o_cmd.load_search = 1'b1;
                        n_state = S_SRCH_RD;
                    end
                end else if (i_stat.rank_ok) begin
                    o_cmd.rank_rd = 1'b1;
                    n_code  = sai_pkg::ST_READ_OK;
                    n_state = S_RESULT;
                end else begin
                    n_code  = sai_pkg::ST_NO_RANK;
                    n_state = S_RESULT;
                end
            end
            S_SRCH_RD: begin
                if (!i_stat.search_done) begin
                    o_cmd.search_rd = 1'b1;
                    n_state = S_SRCH_CMP;
                end else if (i_stat.no_shift) begin
                    n_state = S_WRITE;
                end else begin
                    o_cmd.shift_prime = 1'b1;
                    n_state = S_SH_RUN;
                end
            end
            S_SRCH_CMP: begin
                o_cmd.search_upd = 1'b1;
                n_state = S_SRCH_RD;
            end
            S_SH_RUN: begin
                o_cmd.shift_run = 1'b1;
                if (i_stat.shift_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write_new = 1'b1;
                n_code  = sai_pkg::ST_INSERTED;
                n_state = S_RESULT;
            end
            S_RESULT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= sai_pkg::ST_INSERTED;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

endmodule

[design/sorted_array_insert_core.sv]
// ----------------------------------------------------------------------------
// sorted_array_insert_core: sorted table with binary search insertion
// Top level: joins the controller and the datapath.
// ----------------------------------------------------------------------------
// The core holds up to DEPTH signed 32-bit values in ascending order and
// works on one request at a time. An insert finds the place after all equal
// values by binary search over the table memory, each search step being a
// memory read, then a compare, moves every larger entry up one place at one
// entry per cycle, then stores the value. The table memory has a single read
// port and a single write port. Each request yields exactly one result beat;
// the result sits in an output register, so the next request is taken while
// it waits. The table needs no clearing after reset, since only entries below
// the count are used.
module sorted_array_insert_core #(
    parameter int DEPTH = sai_pkg::DEPTH_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    sai_in_if.sink    i_req,
    sai_out_if.source o_rsp
);

    sai_pkg::t_cmd  cmd;
    sai_pkg::t_stat stat;

    sai_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    sai_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule
